FILE: sv/bsmis_pkg.sv
// shared types and constants for the byte set match index scan
`timescale 1ns / 1ps
`default_nettype none

package bsmis_pkg;

    localparam int POS_W  = 31;
    localparam int DATA_W = 64;
    localparam int NV_W   = 4;
    localparam int CFG_W  = 64;

    localparam logic [POS_W-1:0] CAPACITY_RESET = {POS_W{1'b1}};

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MATCH_SET = 1'b0,
        REG_CAPACITY  = 1'b1
    } cfg_reg_t;

    // result kinds
    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_TOTAL  = 1'b1;

    // per item bookkeeping handed from the scan stage to the serializer
    typedef struct packed {
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] total;
        logic             last;
    } scan_info_t;

endpackage

`default_nettype wire

FILE: sv/bsmis_lane_match.sv
// per lane set compare and capacity limit for one beat
`timescale 1ns / 1ps
`default_nettype none

module bsmis_lane_match
    import bsmis_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire logic [DATA_W-1:0] data_bytes,
    input  wire logic [NV_W-1:0]   nvalid,
    input  wire logic [DATA_W-1:0] match_set,
    input  wire logic [POS_W-1:0]  capacity,
    input  wire logic [POS_W-1:0]  match_count,
    output logic      [LANES-1:0]  emit_mask,
    output logic      [NV_W-1:0]   emit_cnt
);

    logic [POS_W-1:0] room;
    logic [NV_W-1:0]  room_sat;
    logic [NV_W-1:0]  seen;
    logic             hit;

    always_comb
    begin
        room     = (capacity > match_count) ? (capacity - match_count) : '0;
        room_sat = (room > POS_W'(8)) ? NV_W'(8) : room[NV_W-1:0];
        seen     = '0;
        emit_cnt = '0;
        emit_mask = '0;
        for (int j = 0; j < LANES; j++)
        begin
            hit = 1'b0;
            for (int s = 0; s < 8; s++)
            begin
                if (data_bytes[8*j +: 8] == match_set[8*s +: 8])
                begin
                    hit = 1'b1;
                end
            end
            hit = hit && (NV_W'(j) < nvalid);
            // k-th hit is kept only while room remains
            if (hit && (seen < room_sat))
            begin
                emit_mask[j] = 1'b1;
                emit_cnt     = emit_cnt + NV_W'(1);
            end
            if (hit)
            begin
                seen = seen + NV_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/bsmis_serial.sv
// result serializer: one offset or total per cycle into the output register while out_ready allows
`timescale 1ns / 1ps
`default_nettype none

module bsmis_serial
    import bsmis_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [LANES-1:0] load_mask,
    input  wire scan_info_t       load_info,
    output logic                  ser_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  kind,
    output logic      [POS_W-1:0] value,
    output logic                  last_of_run
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic             busy_reg;
    logic [LANES-1:0] mask_reg;
    scan_info_t       info_reg;
    logic             out_valid_reg;
    logic             kind_reg;
    logic [POS_W-1:0] value_reg;
    logic             lor_reg;

    logic [LANES-1:0]  rest;
    logic [LANE_W-1:0] pick;
    logic              has_offset;
    logic              out_load;
    logic              done;

    always_comb
    begin
        pick = '0;
        for (int j = LANES - 1; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                pick = LANE_W'(j);
            end
        end
        has_offset = |mask_reg;
        rest       = mask_reg & (mask_reg - LANES'(1));
        out_load   = busy_reg && (!out_valid_reg || out_ready);
        done       = out_load && (!has_offset || ((rest == '0) && !info_reg.last));
        ser_free   = !busy_reg || done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mask_reg <= load_mask;
            info_reg <= load_info;
        end
        else if (out_load)
        begin
            mask_reg <= rest;
        end
        if (out_load)
        begin
            if (has_offset)
            begin
                kind_reg  <= KIND_OFFSET;
                value_reg <= info_reg.base + POS_W'(pick);
                lor_reg   <= (rest == '0) && !info_reg.last;
            end
            else
            begin
                kind_reg  <= KIND_TOTAL;
                value_reg <= info_reg.total;
                lor_reg   <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign value       = value_reg;
    assign last_of_run = lor_reg;

endmodule

`default_nettype wire

FILE: sv/byte_set_match_index_scan.sv
// top level of the byte set match index scan
// path: a beat passes the input register, the serializer registers and the output register
// throughput: one input beat per cycle while each beat gives at most one result and out_ready allows;
//   a beat with more than one result holds the serializer, which gives one result per cycle while out_ready allows
// reset: rst_n asynchronous active low; clears position, count, pipeline valids,
//   match_set to zero and capacity to all ones
`timescale 1ns / 1ps
`default_nettype none

module byte_set_match_index_scan
    import bsmis_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    // input beats
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] data_bytes,
    input  wire logic [NV_W-1:0]   valid_bytes,
    input  wire logic              last_block,
    // result beats
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic      [POS_W-1:0]  value,
    output logic                   last_of_run
);

    localparam logic [NV_W-1:0] LANES_N = NV_W'(LANES);

    // configuration registers
    logic [DATA_W-1:0] match_set_reg;
    logic [POS_W-1:0]  capacity_reg;

    // input register
    logic              inq_valid_reg;
    logic [DATA_W-1:0] inq_data_reg;
    logic [NV_W-1:0]   inq_nv_reg;
    logic              inq_last_reg;

    // scan state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  cnt_next;
    logic [POS_W-1:0]  total;

    logic [LANES-1:0]  emit_mask;
    logic [NV_W-1:0]   emit_cnt;
    logic              ser_free;
    logic              inq_take;
    logic              ser_load;
    logic              in_fire;
    scan_info_t        info;

    assign cfg_ready = 1'b1;
    assign inq_take  = inq_valid_reg && ser_free;
    assign in_ready  = !inq_valid_reg || inq_take;
    assign in_fire   = in_valid && in_ready;

    // per lane compare against the eight slots, capped by remaining capacity
    bsmis_lane_match #(
        .LANES (LANES)
    ) u_match (
        .data_bytes  (inq_data_reg),
        .nvalid      (inq_nv_reg),
        .match_set   (match_set_reg),
        .capacity    (capacity_reg),
        .match_count (cnt_reg),
        .emit_mask   (emit_mask),
        .emit_cnt    (emit_cnt)
    );

    always_comb
    begin
        total    = cnt_reg + POS_W'(emit_cnt);
        pos_next = inq_last_reg ? '0 : (pos_reg + POS_W'(inq_nv_reg));
        cnt_next = inq_last_reg ? '0 : total;
        // a beat with no kept match and no last flag yields nothing
        ser_load = inq_take && ((emit_mask != '0) || inq_last_reg);
        info.base  = pos_reg;
        info.total = total;
        info.last  = inq_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_set_reg <= '0;
            capacity_reg  <= CAPACITY_RESET;
            inq_valid_reg <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MATCH_SET: match_set_reg <= cfg_data;
                    REG_CAPACITY:  capacity_reg  <= cfg_data[POS_W-1:0];
                    default:       ;
                endcase
            end
            if (in_fire)
            begin
                inq_valid_reg <= 1'b1;
            end
            else if (inq_take)
            begin
                inq_valid_reg <= 1'b0;
            end
            if (inq_take)
            begin
                pos_reg <= pos_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // beat payload, clamped to the lane count on the way in
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            inq_data_reg <= data_bytes;
            inq_nv_reg   <= (valid_bytes > LANES_N) ? LANES_N : valid_bytes;
            inq_last_reg <= last_block;
        end
    end

    // offsets oldest first, then the total on a last beat
    bsmis_serial #(
        .LANES (LANES)
    ) u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ser_load),
        .load_mask   (emit_mask),
        .load_info   (info),
        .ser_free    (ser_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
